/* hw/rtl/assert_macros.svh */
// Assertion macros used by the checker file of this project.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("Assertion failed.");

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("Assertion failed.");

`endif

/* hw/rtl/tse_pkg.sv */
// Widths, codes and reset values of the Taylor series evaluator.
// Depends on nothing.
package tse_pkg;
   localparam int X_W     = 32;
   localparam int A_W     = 40;
   localparam int MAG_W   = 63;
   localparam int PROD_W  = 103;
   localparam int DIV_W   = 12;
   localparam int N_W     = 11;
   localparam int EPS_W   = 31;
   localparam int MT_W    = 10;
   localparam int VALUE_W = 64;
   localparam int FUNC_W  = 3;
   localparam int MCNT_W  = 6;
   localparam int DCNT_W  = 7;

   localparam logic [FUNC_W-1:0] FUNC_SIN  = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_COS  = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_EXP  = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_SINH = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_COSH = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_ATAN = 3'd5;

   localparam logic CSR_EPS       = 1'b0;
   localparam logic CSR_MAX_TERMS = 1'b1;

   localparam logic [EPS_W-1:0] EPS_RESET       = 31'd4295;
   localparam logic [MT_W-1:0]  MAX_TERMS_RESET = 10'd1000;
endpackage

/* hw/rtl/tse_req_if.sv */
// Request channel carrying one item: function select and argument.
// Depends on tse_pkg.
interface tse_req_if;
   logic                          valid;
   logic                          ready;
   logic [tse_pkg::FUNC_W-1:0]    func;
   logic signed [tse_pkg::X_W-1:0] x;
   modport source (output valid, func, x, input ready);
   modport sink   (input valid, func, x, output ready);
endinterface

/* hw/rtl/tse_rsp_if.sv */
// Response channel carrying one result item: series sum and divergence flag.
// Depends on tse_pkg.
interface tse_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [tse_pkg::VALUE_W-1:0] value;
   logic                               divergent;
   modport source (output valid, value, divergent, input ready);
   modport sink   (input valid, value, divergent, output ready);
endinterface

/* hw/rtl/tse_mul.sv */
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on tse_pkg.
module tse_mul (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [tse_pkg::MAG_W-1:0]    m,
   input  logic [tse_pkg::A_W-1:0]      a,
   output logic                         done,
   output logic [tse_pkg::PROD_W-1:0]   prod
);
   logic [tse_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic [tse_pkg::MAG_W-1:0]  m_ff;
   logic [tse_pkg::MCNT_W-1:0] cnt_ff;
   logic                       busy_ff, done_ff;
   logic [tse_pkg::MAG_W:0]    sum;

   always_comb begin
      sum = {1'b0, prod_ff[tse_pkg::PROD_W-1:tse_pkg::A_W]}
            + (prod_ff[0] ? {1'b0, m_ff} : '0);
      prod_in = {sum, prod_ff[tse_pkg::A_W-1:1]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == tse_pkg::MCNT_W'(tse_pkg::A_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         prod_ff <= {{tse_pkg::MAG_W{1'b0}}, a};
         m_ff    <= m;
      end else if (busy_ff) begin
         prod_ff <= prod_in;
      end
   end

   assign done = done_ff;
   assign prod = prod_ff;
endmodule

/* hw/rtl/tse_div.sv */
// Bit-serial restoring divider, one quotient bit per cycle, narrow divisor.
// Depends on tse_pkg.
module tse_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [tse_pkg::PROD_W-1:0]   dividend,
   input  logic [tse_pkg::DIV_W-1:0]    divisor,
   output logic                         done,
   output logic [tse_pkg::PROD_W-1:0]   quotient
);
   logic [tse_pkg::PROD_W-1:0] quo_ff;
   logic [tse_pkg::DIV_W-1:0]  rem_ff, rem_in, d_ff;
   logic [tse_pkg::DCNT_W-1:0] cnt_ff;
   logic                       busy_ff, done_ff, ge;
   logic [tse_pkg::DIV_W:0]    trial, diff;

   always_comb begin
      trial  = {rem_ff, quo_ff[tse_pkg::PROD_W-1]};
      diff   = trial - {1'b0, d_ff};
      ge     = trial >= {1'b0, d_ff};
      rem_in = ge ? diff[tse_pkg::DIV_W-1:0] : trial[tse_pkg::DIV_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == tse_pkg::DCNT_W'(tse_pkg::PROD_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         d_ff   <= divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[tse_pkg::PROD_W-2:0], ge};
         rem_ff <= rem_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

/* hw/rtl/taylor_series_evaluator.sv */
// Top level of the Taylor series evaluator: term sequencer and output register.
// Depends on tse_pkg, tse_req_if, tse_rsp_if, tse_mul and tse_div.
//
// One item at a time. Each series term after the first costs one multiply-divide
// step on the bit-serial multiplier and divider for exp and two for the other
// functions, plus another division for atan and the CHECK and ADD bookkeeping
// states; an item runs up to max_terms + 1 terms.
// Undefined functions and arguments at or below eps finish without a series term.
module taylor_series_evaluator (
   input  logic                             clock,
   input  logic                             reset,
   tse_req_if.sink                          req_ch,
   tse_rsp_if.source                        rsp_ch,
   input  logic                             csr_we,
   input  logic                             csr_index,
   input  logic [tse_pkg::EPS_W-1:0]        csr_wdata
);
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CHECK = 3'd1;
   localparam logic [2:0] ST_MUL   = 3'd2;
   localparam logic [2:0] ST_DIV   = 3'd3;
   localparam logic [2:0] ST_TDIV  = 3'd4;
   localparam logic [2:0] ST_ADD   = 3'd5;
   localparam logic [2:0] ST_OUT   = 3'd6;

   logic [2:0]                        state_ff, state_in;
   logic [tse_pkg::EPS_W-1:0]         eps_ff;
   logic [tse_pkg::MT_W-1:0]          mt_ff;
   logic [tse_pkg::FUNC_W-1:0]        func_ff, func_in;
   logic [tse_pkg::A_W-1:0]           a_ff, a_in;
   logic                              xneg_ff, xneg_in, neg_ff, neg_in;
   logic [tse_pkg::MAG_W-1:0]         mag_ff, mag_in, cur_ff, cur_in, tm_ff, tm_in;
   logic signed [tse_pkg::VALUE_W-1:0] sum_ff, sum_in;
   logic [tse_pkg::N_W-1:0]           n_ff, n_in;
   logic                              second_ff, second_in, div_ff, div_in;
   logic [tse_pkg::DIV_W-1:0]         d2_ff, d2_in;
   logic signed [tse_pkg::VALUE_W-1:0] out_value_ff, out_value_in;
   logic                              out_div_ff, out_div_in, out_valid_ff, out_valid_in;

   logic                              mul_start, mul_done, div_start, div_done;
   logic [tse_pkg::MAG_W-1:0]         mul_m, new_mag;
   logic [tse_pkg::PROD_W-1:0]        mul_prod, div_dividend, div_quo;
   logic [tse_pkg::DIV_W-1:0]         div_d, k, d1;
   logic [tse_pkg::X_W-1:0]           xmag;
   logic signed [tse_pkg::VALUE_W-1:0] term, sum_raw;
   logic                              ovf;

   tse_mul u_mul (
      .clock (clock), .reset (reset), .start (mul_start), .m (mul_m), .a (a_ff),
      .done (mul_done), .prod (mul_prod)
   );

   tse_div u_div (
      .clock (clock), .reset (reset), .start (div_start), .dividend (div_dividend),
      .divisor (div_d), .done (div_done), .quotient (div_quo)
   );

   always_comb begin
      k            = {n_ff[tse_pkg::DIV_W-2:0], 1'b0};
      d1           = k;
      unique case (func_ff)
         tse_pkg::FUNC_COS, tse_pkg::FUNC_COSH: d1 = k - 1'b1;
         tse_pkg::FUNC_EXP:                     d1 = {1'b0, n_ff};
         tse_pkg::FUNC_ATAN:                    d1 = 12'd1;
         default:                               d1 = k;
      endcase

      state_in     = state_ff;
      func_in      = func_ff;
      a_in         = a_ff;
      xneg_in      = xneg_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      cur_in       = cur_ff;
      tm_in        = tm_ff;
      sum_in       = sum_ff;
      n_in         = n_ff;
      second_in    = second_ff;
      div_in       = div_ff;
      d2_in        = d2_ff;
      out_value_in = out_value_ff;
      out_div_in   = out_div_ff;
      out_valid_in = out_valid_ff;
      mul_start    = 1'b0;
      mul_m        = mag_ff;
      div_start    = 1'b0;
      div_dividend = mul_prod;
      div_d        = d1;
      xmag         = req_ch.x[tse_pkg::X_W-1] ? 32'(-req_ch.x) : 32'(req_ch.x);
      new_mag      = (|div_quo[tse_pkg::PROD_W-1:95]) ? {tse_pkg::MAG_W{1'b1}}
                                                       : div_quo[94:32];
      term         = neg_ff ? -$signed({1'b0, tm_ff}) : $signed({1'b0, tm_ff});
      sum_raw      = sum_ff + term;
      ovf          = (sum_ff[63] == term[63]) && (sum_raw[63] != sum_ff[63]);

      if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               func_in = req_ch.func;
               xneg_in = req_ch.x[tse_pkg::X_W-1];
               a_in    = {xmag, 8'd0};
               cur_in  = {23'd0, xmag, 8'd0};
               sum_in  = '0;
               n_in    = '0;
               div_in  = 1'b0;
               state_in = (req_ch.func > tse_pkg::FUNC_ATAN) ? ST_OUT : ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (cur_ff <= {32'd0, eps_ff}) begin
               state_in = ST_OUT;
            end else if (n_ff > {1'b0, mt_ff}) begin
               div_in   = 1'b1;
               state_in = ST_OUT;
            end else if (n_ff == '0) begin
               if (func_ff == tse_pkg::FUNC_COS || func_ff == tse_pkg::FUNC_EXP ||
                   func_ff == tse_pkg::FUNC_COSH) begin
                  mag_in = 63'd1 << 32;
                  tm_in  = 63'd1 << 32;
                  neg_in = 1'b0;
               end else begin
                  mag_in = {23'd0, a_ff};
                  tm_in  = {23'd0, a_ff};
                  neg_in = xneg_ff;
               end
               state_in = ST_ADD;
            end else begin
               mul_start = 1'b1;
               second_in = func_ff != tse_pkg::FUNC_EXP;
               unique case (func_ff)
                  tse_pkg::FUNC_SIN:  begin neg_in = !neg_ff; d2_in = k + 1'b1; end
                  tse_pkg::FUNC_COS:  begin neg_in = !neg_ff; d2_in = k;        end
                  tse_pkg::FUNC_EXP:  begin
                     neg_in = neg_ff ^ xneg_ff;
                     d2_in  = {1'b0, n_ff};
                  end
                  tse_pkg::FUNC_SINH: d2_in = k + 1'b1;
                  tse_pkg::FUNC_COSH: d2_in = k;
                  default:            begin neg_in = !neg_ff; d2_in = 12'd1;  end
               endcase
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            div_d = second_ff ? d1 : d2_ff;
            if (mul_done) begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               mag_in = new_mag;
               if (second_ff) begin
                  second_in = 1'b0;
                  mul_start = 1'b1;
                  mul_m     = new_mag;
                  state_in  = ST_MUL;
               end else if (func_ff == tse_pkg::FUNC_ATAN) begin
                  div_start    = 1'b1;
                  div_dividend = {40'd0, new_mag};
                  div_d        = k + 1'b1;
                  state_in     = ST_TDIV;
               end else begin
                  tm_in    = new_mag;
                  state_in = ST_ADD;
               end
            end
         end
         ST_TDIV: begin
            if (div_done) begin
               tm_in    = div_quo[tse_pkg::MAG_W-1:0];
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            sum_in   = ovf ? (sum_ff[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}}) : sum_raw;
            cur_in   = tm_ff;
            n_in     = n_ff + 1'b1;
            state_in = ST_CHECK;
         end
         ST_OUT: begin
            if (!out_valid_ff || rsp_ch.ready) begin
               out_valid_in = 1'b1;
               out_value_in = sum_ff;
               out_div_in   = div_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // The second multiply of a step divides by d2; the first divides by d1.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         eps_ff       <= tse_pkg::EPS_RESET;
         mt_ff        <= tse_pkg::MAX_TERMS_RESET;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         if (csr_we && csr_index == tse_pkg::CSR_EPS) begin
            eps_ff <= csr_wdata;
         end
         if (csr_we && csr_index == tse_pkg::CSR_MAX_TERMS) begin
            mt_ff <= csr_wdata[tse_pkg::MT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      func_ff      <= func_in;
      a_ff         <= a_in;
      xneg_ff      <= xneg_in;
      neg_ff       <= neg_in;
      mag_ff       <= mag_in;
      cur_ff       <= cur_in;
      tm_ff        <= tm_in;
      sum_ff       <= sum_in;
      n_ff         <= n_in;
      second_ff    <= second_in;
      div_ff       <= div_in;
      d2_ff        <= d2_in;
      out_value_ff <= out_value_in;
      out_div_ff   <= out_div_in;
   end

   assign req_ch.ready     = state_ff == ST_IDLE;
   assign rsp_ch.valid     = out_valid_ff;
   assign rsp_ch.value     = out_value_ff;
   assign rsp_ch.divergent = out_div_ff;
endmodule

/* hw/rtl/tse_checker.sv */
// Port-level checks of the Taylor series evaluator, bound to the top level.
// Depends on assert_macros.svh and tse_pkg.
`include "assert_macros.svh"

module tse_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [tse_pkg::VALUE_W-1:0]      rsp_value
);
   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_value))
   `ASSERT_NEXT(a_no_rsp_after_reset, clock, 1'b0, reset, !rsp_valid)
   `ASSERT_SAME(a_new_rsp_needs_item, clock, reset, $rose(rsp_valid), !req_ready || $past(!req_ready))
endmodule

bind taylor_series_evaluator tse_checker u_tse_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_value (rsp_ch.value)
);
